// ===== rtl/sc3b_pkg.sv =====
package sc3b_pkg;

  localparam int unsigned CoordW           = 32;
  localparam int unsigned DiffW            = 33;
  localparam int unsigned NumAxes          = 3;
  localparam int unsigned NumPlanes        = 6;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned ParamFracBitsDef = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } cfg_reg_e;

  // one lane of the restoring divider: partial remainder, divisor and the
  // two low dividend bits still to be shifted in
  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [CoordW-1:0] den;
    logic              b;
    logic              bn;
  } div_lane_t;

  typedef struct packed {
    logic pzero;  // segment parallel to the plane
    logic qneg;   // start outside the plane
    logic pneg;   // plane raises the entry parameter
    logic rneg;   // ratio is negative
  } plane_flags_t;

  typedef struct packed {
    logic [NumAxes-1:0][CoordW-1:0] s;
    logic [NumAxes-1:0][CoordW-1:0] e;
    logic [NumAxes-1:0][DiffW-1:0]  d;
  } seg_t;

endpackage

// ===== rtl/sc3b_div_cell.sv =====
// One quotient bit for all six planes.
module sc3b_div_cell import sc3b_pkg::*; #(
  parameter int unsigned QW = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  seg_t                                seg_i,
  input  plane_flags_t [NumPlanes-1:0]        flags_i,
  input  div_lane_t    [NumPlanes-1:0]        lane_i,
  input  logic         [NumPlanes-1:0][QW-1:0] quot_i,
  output logic                                valid_o,
  output seg_t                                seg_o,
  output plane_flags_t [NumPlanes-1:0]        flags_o,
  output div_lane_t    [NumPlanes-1:0]        lane_o,
  output logic         [NumPlanes-1:0][QW-1:0] quot_o
);

  logic                                valid_q;
  seg_t                                seg_q;
  plane_flags_t [NumPlanes-1:0]        flags_q;
  div_lane_t    [NumPlanes-1:0]        lane_q, lane_d;
  logic         [NumPlanes-1:0][QW-1:0] quot_q, quot_d;

  for (genvar k = 0; k < NumPlanes; k++) begin : g_lane
    logic [CoordW:0] x, diff;
    logic            ge;
    assign x    = {lane_i[k].rem, lane_i[k].b};
    assign ge   = x >= {1'b0, lane_i[k].den};
    assign diff = x - {1'b0, lane_i[k].den};
    always_comb begin
      lane_d[k].rem = ge ? diff[CoordW-1:0] : x[CoordW-1:0];
      lane_d[k].den = lane_i[k].den;
      lane_d[k].b   = lane_i[k].bn;
      lane_d[k].bn  = 1'b0;
      quot_d[k]     = {quot_i[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q   <= seg_i;
    flags_q <= flags_i;
    lane_q  <= lane_d;
    quot_q  <= quot_d;
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;
  assign flags_o = flags_q;
  assign lane_o  = lane_q;
  assign quot_o  = quot_q;

endmodule

// ===== rtl/sc3b_plane_cell.sv =====
// Tests one plane against the running entry/exit parameters.
module sc3b_plane_cell import sc3b_pkg::*; #(
  parameter int unsigned PF    = 16,
  parameter int unsigned PLANE = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic                                  vis_i,
  input  logic         [PF:0]                   t0_i,
  input  logic         [PF:0]                   t1_i,
  input  seg_t                                  seg_i,
  input  plane_flags_t [NumPlanes-1:0]          flags_i,
  input  logic         [NumPlanes-1:0]          rnz_i,
  input  logic         [NumPlanes-1:0][PF+1:0]  quot_i,
  output logic                                  valid_o,
  output logic                                  vis_o,
  output logic         [PF:0]                   t0_o,
  output logic         [PF:0]                   t1_o,
  output seg_t                                  seg_o,
  output plane_flags_t [NumPlanes-1:0]          flags_o,
  output logic         [NumPlanes-1:0]          rnz_o,
  output logic         [NumPlanes-1:0][PF+1:0]  quot_o
);

  localparam int unsigned QW = PF + 2;
  localparam int unsigned RW = PF + 3;
  localparam logic [QW-1:0] TopVal = QW'((64'd1 << PF) + 64'd1);

  logic [QW-1:0]        m, pos;
  logic signed [RW-1:0] r, t0x, t1x;
  plane_flags_t         f;
  logic                 vis_d;
  logic [PF:0]          t0_d, t1_d;

  logic                                  valid_q, vis_q;
  logic         [PF:0]                   t0_q, t1_q;
  seg_t                                  seg_q;
  plane_flags_t [NumPlanes-1:0]          flags_q;
  logic         [NumPlanes-1:0]          rnz_q;
  logic         [NumPlanes-1:0][PF+1:0]  quot_q;

  assign m   = quot_i[PLANE];
  assign f   = flags_i[PLANE];
  assign pos = (m > TopVal) ? TopVal : m;
  assign t0x = $signed({2'b00, t0_i});
  assign t1x = $signed({2'b00, t1_i});

  // saturated ratio: -1 stands for below 0.0, TopVal for above 1.0
  always_comb begin
    if (f.rneg) begin
      r = ((m != '0) || rnz_i[PLANE]) ? {RW{1'b1}} : '0;
    end else begin
      r = $signed({1'b0, pos});
    end
  end

  always_comb begin
    vis_d = vis_i;
    t0_d  = t0_i;
    t1_d  = t1_i;
    if (vis_i) begin
      if (f.pzero) begin
        if (f.qneg) vis_d = 1'b0;
      end else if (f.pneg) begin
        if (r > t1x) vis_d = 1'b0;
        else if (r > t0x) t0_d = r[PF:0];
      end else begin
        if (r < t0x) vis_d = 1'b0;
        else if (r < t1x) t1_d = r[PF:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q   <= vis_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    seg_q   <= seg_i;
    flags_q <= flags_i;
    rnz_q   <= rnz_i;
    quot_q  <= quot_i;
  end

  assign valid_o = valid_q;
  assign vis_o   = vis_q;
  assign t0_o    = t0_q;
  assign t1_o    = t1_q;
  assign seg_o   = seg_q;
  assign flags_o = flags_q;
  assign rnz_o   = rnz_q;
  assign quot_o  = quot_q;

endmodule

// ===== rtl/segment_clip_3d_box.sv =====
// Channel   Handshake          Fields
// config    cfg_we_i           cfg_idx_i, cfg_data_i (box bounds, Q16.16)
// segment   start & !busy      start_{x,y,z}_i, end_{x,y,z}_i
// result    done_o (1 cycle)   visible_o, t_enter_o, t_exit_o, clip_*_o
//
// One segment transfer per cycle; busy never rises.
// Pipeline: one entry stage, PARAM_FRAC_BITS + 2 divider cells (one quotient
// bit each, six planes in parallel), six plane cells, a multiply stage and
// the output register.
// Reset clears the box bounds to zero and empties the pipeline.
// The receiver cannot stall: each result shows for exactly one cycle.
module segment_clip_3d_box import sc3b_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = ParamFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CoordW-1:0]         cfg_data_i,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [CoordW-1:0]  start_x_i,
  input  logic signed [CoordW-1:0]  start_y_i,
  input  logic signed [CoordW-1:0]  start_z_i,
  input  logic signed [CoordW-1:0]  end_x_i,
  input  logic signed [CoordW-1:0]  end_y_i,
  input  logic signed [CoordW-1:0]  end_z_i,
  output logic                      done_o,
  output logic                      visible_o,
  output logic [PARAM_FRAC_BITS:0]  t_enter_o,
  output logic [PARAM_FRAC_BITS:0]  t_exit_o,
  output logic signed [CoordW-1:0]  clip_start_x_o,
  output logic signed [CoordW-1:0]  clip_start_y_o,
  output logic signed [CoordW-1:0]  clip_start_z_o,
  output logic signed [CoordW-1:0]  clip_end_x_o,
  output logic signed [CoordW-1:0]  clip_end_y_o,
  output logic signed [CoordW-1:0]  clip_end_z_o
);

  localparam int unsigned PF     = PARAM_FRAC_BITS;
  localparam int unsigned TW     = PF + 1;
  localparam int unsigned QW     = PF + 2;
  localparam int unsigned NumDiv = QW;
  localparam int unsigned PW     = TW + 1 + DiffW;
  localparam logic [TW-1:0] TOne = {1'b1, {PF{1'b0}}};

  // ---------------- box registers ----------------
  logic [CoordW-1:0] box_q [2*NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * NumAxes; i++) box_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegMinX: box_q[0] <= cfg_data_i;
        RegMinY: box_q[1] <= cfg_data_i;
        RegMinZ: box_q[2] <= cfg_data_i;
        RegMaxX: box_q[3] <= cfg_data_i;
        RegMaxY: box_q[4] <= cfg_data_i;
        RegMaxZ: box_q[5] <= cfg_data_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- entry stage ----------------
  // Differences and magnitudes are formed from two subtractions in
  // parallel, picking by sign, so only one adder level sits here.
  logic [CoordW-1:0] s_in [NumAxes];
  logic [CoordW-1:0] e_in [NumAxes];
  seg_t                         seg_d;
  plane_flags_t [NumPlanes-1:0] flags_d;
  div_lane_t    [NumPlanes-1:0] lane_d;

  assign s_in[0] = start_x_i;
  assign s_in[1] = start_y_i;
  assign s_in[2] = start_z_i;
  assign e_in[0] = end_x_i;
  assign e_in[1] = end_y_i;
  assign e_in[2] = end_z_i;

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic [DiffW-1:0] d, nd, qa_lo, qb_lo, qa_hi, qb_hi;
    logic [CoordW-1:0] absp, absq_lo, absq_hi;
    assign d     = {e_in[a][CoordW-1], e_in[a]} - {s_in[a][CoordW-1], s_in[a]};
    assign nd    = {s_in[a][CoordW-1], s_in[a]} - {e_in[a][CoordW-1], e_in[a]};
    // min plane: q = s - min; max plane: q = max - s
    assign qa_lo = {s_in[a][CoordW-1], s_in[a]} - {box_q[a][CoordW-1], box_q[a]};
    assign qb_lo = {box_q[a][CoordW-1], box_q[a]} - {s_in[a][CoordW-1], s_in[a]};
    assign qa_hi = {box_q[a+3][CoordW-1], box_q[a+3]} - {s_in[a][CoordW-1], s_in[a]};
    assign qb_hi = {s_in[a][CoordW-1], s_in[a]} - {box_q[a+3][CoordW-1], box_q[a+3]};
    assign absp    = d[DiffW-1] ? nd[CoordW-1:0] : d[CoordW-1:0];
    assign absq_lo = qa_lo[DiffW-1] ? qb_lo[CoordW-1:0] : qa_lo[CoordW-1:0];
    assign absq_hi = qa_hi[DiffW-1] ? qb_hi[CoordW-1:0] : qa_hi[CoordW-1:0];

    always_comb begin
      seg_d.s[a] = s_in[a];
      seg_d.e[a] = e_in[a];
      seg_d.d[a] = d;

      // min plane, p = -d
      flags_d[2*a].pzero = (d == '0);
      flags_d[2*a].qneg  = qa_lo[DiffW-1];
      flags_d[2*a].pneg  = nd[DiffW-1];
      flags_d[2*a].rneg  = (qa_lo != '0) && (qa_lo[DiffW-1] != nd[DiffW-1]);
      lane_d[2*a].rem    = {2'b00, absq_lo[CoordW-1:2]};
      lane_d[2*a].den    = absp;
      lane_d[2*a].b      = absq_lo[1];
      lane_d[2*a].bn     = absq_lo[0];

      // max plane, p = d
      flags_d[2*a+1].pzero = (d == '0);
      flags_d[2*a+1].qneg  = qa_hi[DiffW-1];
      flags_d[2*a+1].pneg  = d[DiffW-1];
      flags_d[2*a+1].rneg  = (qa_hi != '0) && (qa_hi[DiffW-1] != d[DiffW-1]);
      lane_d[2*a+1].rem    = {2'b00, absq_hi[CoordW-1:2]};
      lane_d[2*a+1].den    = absp;
      lane_d[2*a+1].b      = absq_hi[1];
      lane_d[2*a+1].bn     = absq_hi[0];
    end
  end

  // ---------------- divider chain ----------------
  // Cell 0 yields the overflow bit (ratio >= 2.0), the rest one bit each.
  logic                                  dv_valid [NumDiv+1];
  seg_t                                  dv_seg   [NumDiv+1];
  plane_flags_t [NumPlanes-1:0]          dv_flags [NumDiv+1];
  div_lane_t    [NumPlanes-1:0]          dv_lane  [NumDiv+1];
  logic         [NumPlanes-1:0][QW-1:0]  dv_quot  [NumDiv+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_seg[0]   <= seg_d;
    dv_flags[0] <= flags_d;
    dv_lane[0]  <= lane_d;
  end

  assign dv_quot[0] = '0;

  for (genvar i = 0; i < NumDiv; i++) begin : g_div
    sc3b_div_cell #(.QW(QW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .seg_i   (dv_seg[i]),
      .flags_i (dv_flags[i]),
      .lane_i  (dv_lane[i]),
      .quot_i  (dv_quot[i]),
      .valid_o (dv_valid[i+1]),
      .seg_o   (dv_seg[i+1]),
      .flags_o (dv_flags[i+1]),
      .lane_o  (dv_lane[i+1]),
      .quot_o  (dv_quot[i+1])
    );
  end

  // ---------------- plane chain ----------------
  logic                                  pl_valid [NumPlanes+1];
  logic                                  pl_vis   [NumPlanes+1];
  logic         [TW-1:0]                 pl_t0    [NumPlanes+1];
  logic         [TW-1:0]                 pl_t1    [NumPlanes+1];
  seg_t                                  pl_seg   [NumPlanes+1];
  plane_flags_t [NumPlanes-1:0]          pl_flags [NumPlanes+1];
  logic         [NumPlanes-1:0]          pl_rnz   [NumPlanes+1];
  logic         [NumPlanes-1:0][QW-1:0]  pl_quot  [NumPlanes+1];

  assign pl_valid[0] = dv_valid[NumDiv];
  assign pl_vis[0]   = 1'b1;
  assign pl_t0[0]    = '0;
  assign pl_t1[0]    = TOne;
  assign pl_seg[0]   = dv_seg[NumDiv];
  assign pl_flags[0] = dv_flags[NumDiv];
  assign pl_quot[0]  = dv_quot[NumDiv];

  for (genvar k = 0; k < NumPlanes; k++) begin : g_rnz
    assign pl_rnz[0][k] = |dv_lane[NumDiv][k].rem;
  end

  // planes in order: x min, x max, y min, y max, z min, z max
  for (genvar k = 0; k < NumPlanes; k++) begin : g_plane
    sc3b_plane_cell #(.PF(PF), .PLANE(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pl_valid[k]),
      .vis_i   (pl_vis[k]),
      .t0_i    (pl_t0[k]),
      .t1_i    (pl_t1[k]),
      .seg_i   (pl_seg[k]),
      .flags_i (pl_flags[k]),
      .rnz_i   (pl_rnz[k]),
      .quot_i  (pl_quot[k]),
      .valid_o (pl_valid[k+1]),
      .vis_o   (pl_vis[k+1]),
      .t0_o    (pl_t0[k+1]),
      .t1_o    (pl_t1[k+1]),
      .seg_o   (pl_seg[k+1]),
      .flags_o (pl_flags[k+1]),
      .rnz_o   (pl_rnz[k+1]),
      .quot_o  (pl_quot[k+1])
    );
  end

  // ---------------- interpolation ----------------
  // clip = s + floor(t * d / 2^PF) for a visible segment (else s and e pass
  // through): product registered, then an arithmetic shift and one add.
  logic                 mul_valid_q, mul_vis_q;
  logic [TW-1:0]        mul_t0_q, mul_t1_q;
  seg_t                 mul_seg_q;
  logic signed [PW-1:0] prod_s_q [NumAxes];
  logic signed [PW-1:0] prod_e_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= pl_valid[NumPlanes];
    end
  end

  always_ff @(posedge clk_i) begin
    mul_vis_q <= pl_vis[NumPlanes];
    mul_t0_q  <= pl_t0[NumPlanes];
    mul_t1_q  <= pl_t1[NumPlanes];
    mul_seg_q <= pl_seg[NumPlanes];
    for (int a = 0; a < NumAxes; a++) begin
      prod_s_q[a] <= $signed({1'b0, pl_t0[NumPlanes]}) * $signed(pl_seg[NumPlanes].d[a]);
      prod_e_q[a] <= $signed({1'b0, pl_t1[NumPlanes]}) * $signed(pl_seg[NumPlanes].d[a]);
    end
  end

  logic [CoordW-1:0] cs_d [NumAxes];
  logic [CoordW-1:0] ce_d [NumAxes];

  for (genvar a = 0; a < NumAxes; a++) begin : g_lerp
    logic signed [PW-1:0] off_s, off_e;
    assign off_s = prod_s_q[a] >>> PF;
    assign off_e = prod_e_q[a] >>> PF;
    assign cs_d[a] = mul_vis_q ? mul_seg_q.s[a] + off_s[CoordW-1:0] : mul_seg_q.s[a];
    assign ce_d[a] = mul_vis_q ? mul_seg_q.s[a] + off_e[CoordW-1:0] : mul_seg_q.e[a];
  end

  // ---------------- output register ----------------
  logic              done_q, vis_q;
  logic [TW-1:0]     t0_q, t1_q;
  logic [CoordW-1:0] cs_q [NumAxes];
  logic [CoordW-1:0] ce_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= mul_vis_q;
    t0_q  <= mul_t0_q;
    t1_q  <= mul_t1_q;
    for (int a = 0; a < NumAxes; a++) begin
      cs_q[a] <= cs_d[a];
      ce_q[a] <= ce_d[a];
    end
  end

  assign done_o         = done_q;
  assign visible_o      = vis_q;
  assign t_enter_o      = t0_q;
  assign t_exit_o       = t1_q;
  assign clip_start_x_o = cs_q[0];
  assign clip_start_y_o = cs_q[1];
  assign clip_start_z_o = cs_q[2];
  assign clip_end_x_o   = ce_q[0];
  assign clip_end_y_o   = ce_q[1];
  assign clip_end_z_o   = ce_q[2];

`ifndef SYNTHESIS
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && visible_o |-> t_enter_o <= t_exit_o)
    else $error("visible result with entry past exit");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (t_enter_o <= TOne) && (t_exit_o <= TOne))
    else $error("parameter outside [0, 1]");

  a_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && visible_o && (t_enter_o == t_exit_o) |->
      (clip_start_x_o == clip_end_x_o) && (clip_start_y_o == clip_end_y_o) &&
      (clip_start_z_o == clip_end_z_o))
    else $error("equal parameters gave different endpoints");
`endif

endmodule
